// ===== hw/rtl/iwpf_pkg.sv =====
`default_nettype none

package iwpf_pkg;

  localparam int PACKET_BYTES = 56;
  localparam int OFF_W        = 6;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;

  localparam logic [7:0] SYNC_BYTE0 = 8'h57;
  localparam logic [7:0] SYNC_BYTE1 = 8'hAB;
  localparam logic [7:0] CMD_WRITE  = 8'hA5;
  localparam logic [7:0] CMD_VERIFY = 8'hA6;
  localparam logic [7:0] LEN_BASE   = 8'h05;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ADDEND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERIFY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SERIAL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_VALUE   = 3'd5;

  // Everything the back end needs to emit the bytes caused by one image item.
  typedef struct packed {
    logic       hdr;
    logic       serial;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [15:0] addr;
    logic [7:0] data;
    logic       close;
    logic [2:0] pad_cnt;
    logic [7:0] pad_lo;
    logic [7:0] pad_hi;
  } desc_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC0,
    PH_SYNC1,
    PH_CMD,
    PH_LEN,
    PH_ZERO0,
    PH_ADDR_LO,
    PH_ADDR_HI,
    PH_ZERO1,
    PH_ZERO2,
    PH_ZERO3,
    PH_DATA,
    PH_PAD,
    PH_SUM
  } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iwpf_front.sv =====
`default_nettype none

module iwpf_front
  import iwpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  accept,
  input  wire logic [7:0]            image_byte,
  output desc_t                      desc
);

  logic [7:0]       mask_base;
  logic [7:0]       mask_last_addend;
  logic [15:0]      image_length;
  logic             verify_mode;
  logic             serial_wrap;
  logic [7:0]       pad_value;

  logic [OFF_W-1:0] offset;
  logic [15:0]      consumed;

  logic [15:0]      remaining;
  logic             full_size;
  logic [OFF_W-1:0] rounded;
  logic [OFF_W-1:0] size;
  logic [7:0]       mask7;
  logic [OFF_W-1:0] off_inc;
  logic [15:0]      consumed_inc;
  logic             last_img;
  logic             close;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_base        <= 8'd0;
      mask_last_addend <= 8'd0;
      image_length     <= 16'd1;
      verify_mode      <= 1'b0;
      serial_wrap      <= 1'b1;
      pad_value        <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASK_BASE:   mask_base        <= cfg_data[7:0];
        REG_MASK_ADDEND: mask_last_addend <= cfg_data[7:0];
        REG_IMAGE_LEN:   image_length     <= cfg_data;
        REG_VERIFY:      verify_mode      <= cfg_data[0];
        REG_SERIAL:      serial_wrap      <= cfg_data[0];
        REG_PAD_VALUE:   pad_value        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    remaining    = image_length - consumed;
    // A remainder of zero stands for a full 64K image.
    full_size    = (remaining == 16'd0) || (remaining >= 16'(PACKET_BYTES));
    rounded      = (remaining[OFF_W-1:0] + OFF_W'(7)) & ~OFF_W'(7);
    size         = full_size ? OFF_W'(PACKET_BYTES) : rounded;
    mask7        = mask_base + mask_last_addend;
    off_inc      = offset + OFF_W'(1);
    consumed_inc = consumed + 16'd1;
    last_img     = (consumed_inc == image_length);
    close        = last_img || (off_inc >= OFF_W'(PACKET_BYTES));

    desc.hdr     = (offset == '0);
    desc.serial  = serial_wrap;
    desc.cmd     = verify_mode ? CMD_VERIFY : CMD_WRITE;
    desc.len     = LEN_BASE + {{(8-OFF_W){1'b0}}, size};
    desc.addr    = consumed;
    desc.data    = image_byte ^ ((offset[2:0] == 3'd7) ? mask7 : mask_base);
    desc.close   = close;
    // Padding runs up to the next multiple of eight, so its last byte sits at mask slot seven.
    desc.pad_cnt = last_img ? (3'd0 - off_inc[2:0]) : 3'd0;
    desc.pad_lo  = pad_value ^ mask_base;
    desc.pad_hi  = pad_value ^ mask7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset   <= '0;
      consumed <= 16'd0;
    end else if (accept) begin
      offset   <= close ? '0 : off_inc;
      consumed <= last_img ? 16'd0 : consumed_inc;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iwpf_queue.sv =====
`default_nettype none

module iwpf_queue
  import iwpf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  wr_en,
  input  wire desc_t wr_desc,
  output logic       full,
  input  wire logic  rd_en,
  output desc_t      rd_desc,
  output logic       empty
);

  desc_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_desc = slots[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (rd_en) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/iwpf_back.sv =====
`default_nettype none

module iwpf_back
  import iwpf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire desc_t      head,
  input  wire logic       q_empty,
  output logic            q_pop,
  input  wire logic       pop,
  output logic            out_valid,
  output logic [7:0]      out_byte,
  output logic            out_end
);

  phase_t     phase;
  phase_t     phase_next;
  logic [2:0] pad_left;
  logic [7:0] sum;

  logic       fire;
  logic [7:0] emit_byte;
  logic       emit_end;
  logic       summed;

  assign fire = (phase != PH_IDLE) && (!out_valid || pop);

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE: begin
        if (!q_empty) begin
          if (head.hdr) begin
            phase_next = head.serial ? PH_SYNC0 : PH_CMD;
          end else begin
            phase_next = PH_DATA;
          end
        end
      end
      PH_SYNC0:   if (fire) phase_next = PH_SYNC1;
      PH_SYNC1:   if (fire) phase_next = PH_CMD;
      PH_CMD:     if (fire) phase_next = PH_LEN;
      PH_LEN:     if (fire) phase_next = PH_ZERO0;
      PH_ZERO0:   if (fire) phase_next = PH_ADDR_LO;
      PH_ADDR_LO: if (fire) phase_next = PH_ADDR_HI;
      PH_ADDR_HI: if (fire) phase_next = PH_ZERO1;
      PH_ZERO1:   if (fire) phase_next = PH_ZERO2;
      PH_ZERO2:   if (fire) phase_next = PH_ZERO3;
      PH_ZERO3:   if (fire) phase_next = PH_DATA;
      PH_DATA: begin
        if (fire) begin
          if (head.close && (head.pad_cnt != 3'd0)) begin
            phase_next = PH_PAD;
          end else if (head.close && head.serial) begin
            phase_next = PH_SUM;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      end
      PH_PAD: begin
        if (fire && (pad_left == 3'd1)) begin
          phase_next = head.serial ? PH_SUM : PH_IDLE;
        end
      end
      PH_SUM:     if (fire) phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  always_comb begin
    emit_byte = ZERO_BYTE;
    emit_end  = 1'b0;
    summed    = 1'b1;
    case (phase)
      PH_SYNC0: begin
        emit_byte = SYNC_BYTE0;
        summed    = 1'b0;
      end
      PH_SYNC1: begin
        emit_byte = SYNC_BYTE1;
        summed    = 1'b0;
      end
      PH_CMD:     emit_byte = head.cmd;
      PH_LEN:     emit_byte = head.len;
      PH_ADDR_LO: emit_byte = head.addr[7:0];
      PH_ADDR_HI: emit_byte = head.addr[15:8];
      PH_DATA: begin
        emit_byte = head.data;
        emit_end  = head.close && !head.serial && (head.pad_cnt == 3'd0);
      end
      PH_PAD: begin
        emit_byte = (pad_left == 3'd1) ? head.pad_hi : head.pad_lo;
        emit_end  = (pad_left == 3'd1) && !head.serial;
      end
      PH_SUM: begin
        emit_byte = sum;
        emit_end  = 1'b1;
        summed    = 1'b0;
      end
      PH_IDLE:    summed = 1'b0;
      default:    emit_byte = ZERO_BYTE;
    endcase
    q_pop = fire && (phase_next == PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= emit_byte;
      out_end  <= emit_end;
      // The checksum restarts with the command byte of each frame.
      if (phase == PH_CMD) begin
        sum <= emit_byte;
      end else if (summed) begin
        sum <= sum + emit_byte;
      end
      if (phase == PH_DATA) begin
        pad_left <= head.pad_cnt;
      end else if (phase == PH_PAD) begin
        pad_left <= pad_left - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/isp_write_packet_framer_unit.sv =====
`default_nettype none

// Channel   Handshake                 Payload
// input     push / full               image_byte
// results   empty / pop               frame_byte, frame_end
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// The front end classifies each image item in the cycle it is accepted and queues a
// descriptor (four deep); the back end emits one frame byte per cycle from it while
// results are popped. A mid-packet item takes a dispatch step and its data byte in the
// back end; a packet start adds the header bytes, the image end pad bytes up to the next
// multiple of eight, and every packet close in serial mode a checksum byte.
// Reset clears counters, queue and output register and loads the register defaults.
// Either side may stall freely; the queue and the output register keep them apart.
module isp_write_packet_framer_unit
  import iwpf_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            image_byte,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 frame_byte,
  output logic                       frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  desc_t front_desc;
  desc_t head_desc;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  logic  accept;
  logic  out_valid;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  iwpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .image_byte (image_byte),
    .desc       (front_desc)
  );

  iwpf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_desc (front_desc),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_desc (head_desc),
    .empty   (q_empty)
  );

  iwpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .pop       (pop),
    .out_valid (out_valid),
    .out_byte  (frame_byte),
    .out_end   (frame_end)
  );

endmodule

`default_nettype wire

// ===== test/tb_isp_write_packet_framer_unit.sv =====
module tb_isp_write_packet_framer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import iwpf_pkg::*;

  localparam int RANDOM_ITEMS   = 370;
  localparam int LONG_IMAGE_MIN = 281;
  localparam int SETTLE_CYCLES  = 12;
  localparam int STALL_LIMIT    = 2000;

  localparam logic [71:0] CORNER_BYTES = 72'h00_FF_55_AA_01_80_7F_FE_3C;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  push       = 1'b0;
  logic                  full;
  logic [7:0]            image_byte = 8'h00;
  logic                  empty;
  logic                  pop        = 1'b0;
  logic [7:0]            frame_byte;
  logic                  frame_end;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  isp_write_packet_framer_unit dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .image_byte (image_byte),
    .empty      (empty),
    .pop        (pop),
    .frame_byte (frame_byte),
    .frame_end  (frame_end),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Register copies and framing state, starting from their reset values.
  logic [7:0]  mask_base_q = 8'h00;
  logic [7:0]  mask_add_q  = 8'h00;
  logic [15:0] image_len_q = 16'd1;
  logic        verify_q    = 1'b0;
  logic        serial_q    = 1'b1;
  logic [7:0]  pad_q       = 8'h00;

  int unsigned pkt_offset = 0;
  logic [15:0] pkt_addr   = 16'h0000;
  logic [15:0] consumed   = 16'h0000;
  logic [7:0]  cmd_sum    = 8'h00;

  frame_out_t  frame_bytes_due[$];
  logic [7:0]  image_backlog[$];
  int          mismatches = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [7:0] mask_at_pos(input int unsigned pos);
    return ((pos % 8) == 7) ? mask_base_q + mask_add_q : mask_base_q;
  endfunction

  function automatic int unsigned padded_len(input int unsigned count);
    int unsigned rounded;
    rounded = (count + 7) / 8 * 8;
    return (rounded > PACKET_BYTES) ? PACKET_BYTES : rounded;
  endfunction

  function automatic void emit_frame_byte(input logic [7:0] value, input bit summed);
    frame_out_t fb;
    fb.data = value;
    fb.last = 1'b0;
    frame_bytes_due.push_back(fb);
    if (summed) cmd_sum = cmd_sum + value;
  endfunction

  function automatic void frame_image_byte(input logic [7:0] value);
    logic [15:0] left;
    logic [15:0] next_count;
    logic [7:0]  size_byte;
    int unsigned remaining;
    int unsigned off;
    int unsigned target;
    bit          image_done;
    frame_out_t  tail;
    if (pkt_offset == 0) begin
      left      = image_len_q - consumed;
      remaining = (left == 16'd0) ? 65536 : left;
      size_byte = 8'((remaining >= PACKET_BYTES) ? PACKET_BYTES : padded_len(remaining));
      pkt_addr  = consumed;
      cmd_sum   = 8'h00;
      if (serial_q) begin
        emit_frame_byte(SYNC_BYTE0, 1'b0);
        emit_frame_byte(SYNC_BYTE1, 1'b0);
      end
      emit_frame_byte(verify_q ? CMD_VERIFY : CMD_WRITE, 1'b1);
      emit_frame_byte(LEN_BASE + size_byte, 1'b1);
      emit_frame_byte(ZERO_BYTE, 1'b1);
      emit_frame_byte(pkt_addr[7:0], 1'b1);
      emit_frame_byte(pkt_addr[15:8], 1'b1);
      emit_frame_byte(ZERO_BYTE, 1'b1);
      emit_frame_byte(ZERO_BYTE, 1'b1);
      emit_frame_byte(ZERO_BYTE, 1'b1);
    end
    off = pkt_offset;
    emit_frame_byte(value ^ mask_at_pos(off), 1'b1);
    off++;
    next_count = consumed + 16'd1;
    image_done = (next_count == image_len_q);
    consumed   = next_count;
    if (image_done || off >= PACKET_BYTES) begin
      if (image_done) begin
        target = padded_len(off);
        while (off < target) begin
          emit_frame_byte(pad_q ^ mask_at_pos(off), 1'b1);
          off++;
        end
      end
      if (serial_q) emit_frame_byte(cmd_sum, 1'b0);
      tail      = frame_bytes_due.pop_back();
      tail.last = 1'b1;
      frame_bytes_due.push_back(tail);
      pkt_offset = 0;
      if (image_done) begin
        consumed = 16'h0000;
        pkt_addr = 16'h0000;
        cmd_sum  = 8'h00;
      end
    end else begin
      pkt_offset = off;
    end
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sender: bursts of items separated by random gaps.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) frame_image_byte(image_byte);
      if (!push || !full) begin
        if (gap_left != 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (image_backlog.size() != 0) begin
          push       <= 1'b1;
          image_byte <= image_backlog.pop_front();
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: pops follow an 8-bit pattern, replaced when its randomly drawn age runs out.
  logic [7:0]  pop_pattern = 8'hFF;
  int unsigned pattern_age = 0;
  int unsigned pattern_bit = 0;

  always @(posedge clk) begin
    frame_out_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: frame item expected none, actual byte %02h end %b",
                   $time, frame_byte, frame_end);
          mismatches++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (frame_byte !== want.data) begin
            $display("%0t: frame_byte expected %02h actual %02h", $time, want.data, frame_byte);
            mismatches++;
          end
          if (frame_end !== want.last) begin
            $display("%0t: frame_end expected %b actual %b", $time, want.last, frame_end);
            mismatches++;
          end
        end
      end
      if (pattern_age == 0) begin
        case ($urandom_range(0, 3))
          0: pop_pattern = 8'hFF;
          1: pop_pattern = 8'h01;
          default: begin
            pop_pattern    = 8'($urandom_range(0, 255));
            pop_pattern[0] = 1'b1;
          end
        endcase
        pattern_age = $urandom_range(16, 80);
      end
      pattern_age--;
      pop <= pop_pattern[pattern_bit];
      pattern_bit = (pattern_bit + 1) % 8;
    end
  end

  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MASK_BASE:   mask_base_q = value[7:0];
      REG_MASK_ADDEND: mask_add_q  = value[7:0];
      REG_IMAGE_LEN:   image_len_q = value;
      REG_VERIFY:      verify_q    = value[0];
      REG_SERIAL:      serial_q    = value[0];
      REG_PAD_VALUE:   pad_q       = value[7:0];
      default: ;
    endcase
  endtask

  // Every item causes at least one frame byte, so an empty store means the block is idle.
  task automatic settle();
    do @(negedge clk); while (image_backlog.size() != 0 || push || frame_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic queue_image_bytes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) image_backlog.push_back(pick_byte());
  endtask

  initial begin
    logic [15:0] new_len;
    logic [15:0] left;
    int unsigned remaining;
    int unsigned count;
    int unsigned span;
    int unsigned random_items;
    int unsigned sel;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings give a one-byte image with serial framing: seven pad bytes per frame.
    image_backlog.push_back(8'h00);
    image_backlog.push_back(8'hFF);
    settle();

    // Position seven mask wraps to zero; nine bytes pad out to sixteen.
    write_reg(REG_MASK_BASE, 16'h00FF);
    write_reg(REG_MASK_ADDEND, 16'h0001);
    write_reg(REG_IMAGE_LEN, 16'd9);
    write_reg(REG_VERIFY, 16'd1);
    write_reg(REG_SERIAL, 16'd0);
    write_reg(REG_PAD_VALUE, 16'h00FF);
    for (int i = 8; i >= 0; i--) image_backlog.push_back(CORNER_BYTES[8*i +: 8]);
    settle();

    // An image that is an exact multiple of eight needs no padding.
    write_reg(REG_SERIAL, 16'd1);
    write_reg(REG_VERIFY, 16'd0);
    write_reg(REG_MASK_BASE, 16'h0080);
    write_reg(REG_MASK_ADDEND, 16'h007F);
    write_reg(REG_PAD_VALUE, 16'h0000);
    write_reg(REG_IMAGE_LEN, 16'd8);
    for (int i = 7; i >= 0; i--) image_backlog.push_back(CORNER_BYTES[8*i +: 8]);
    settle();

    // Zero length stands for a full 64K image; shorten it in the middle of the packet.
    write_reg(REG_VERIFY, 16'd1);
    write_reg(REG_IMAGE_LEN, 16'd0);
    queue_image_bytes(5);
    settle();
    write_reg(REG_MASK_BASE, 16'h0000);
    write_reg(REG_PAD_VALUE, 16'h005A);
    write_reg(REG_IMAGE_LEN, consumed + 16'd3);
    queue_image_bytes(3);
    settle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      write_reg(REG_MASK_BASE, {8'h00, pick_byte()});
      write_reg(REG_MASK_ADDEND, {8'h00, pick_byte()});
      write_reg(REG_VERIFY, 16'($urandom_range(0, 1)));
      write_reg(REG_SERIAL, 16'($urandom_range(0, 1)));
      write_reg(REG_PAD_VALUE, {8'h00, pick_byte()});
      if (random_items < LONG_IMAGE_MIN) begin
        // A long image sent in chunks carries packet addresses past 256, and the
        // settings change between chunks in the middle of packets.
        new_len = 16'd0;
        count   = $urandom_range(40, 70);
      end else begin
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
          new_len = 16'hFFFF;
        end else begin
          case ($urandom_range(0, 7))
            0:       span = 1;
            1:       span = PACKET_BYTES;
            2:       span = PACKET_BYTES + 1;
            3:       span = PACKET_BYTES - 1;
            4:       span = $urandom_range(2, 9);
            default: span = $urandom_range(1, 64);
          endcase
          new_len = 16'(consumed + span);
        end
        left      = new_len - consumed;
        remaining = (left == 16'd0) ? 65536 : left;
        if (sel == 0) begin
          count = $urandom_range(1, 60);
        end else if ($urandom_range(0, 3) == 0 && remaining > 1) begin
          count = $urandom_range(1, remaining - 1);
        end else begin
          count = remaining;
          // A second image right behind the first restarts at address zero.
          if (consumed == 0 && $urandom_range(0, 3) == 0) count += remaining;
        end
      end
      write_reg(REG_IMAGE_LEN, new_len);
      if ($urandom_range(0, 2) == 0 && count > 1) begin
        queue_image_bytes(count / 2);
        settle();
        queue_image_bytes(count - count / 2);
      end else begin
        queue_image_bytes(count);
      end
      random_items += count;
      settle();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
